// ===== hw/rtl/pwcf_pkg.sv =====
package pwcf_pkg;

    localparam int PAD_WORD_W  = 20;
    localparam int INDEX_W     = 7;
    localparam int CELL_Z_W    = 7;
    localparam int CELL_WIRE_W = 6;
    localparam int NUM_PAT     = 3;
    localparam int PAT_W       = 2;

    // most cells one word may give
    localparam int MAX_ITEM_CELLS = 60;

    // pattern offset of a pad in an earlier word relative to the current bit
    typedef logic signed [1:0] off_t;

    localparam off_t OFF_ZERO  = 2'sd0;
    localparam off_t OFF_PLUS  = 2'sd1;
    localparam off_t OFF_MINUS = -2'sd1;

    // z mod 3 selects the pattern set
    localparam logic [1:0] ZM_0 = 2'd0;
    localparam logic [1:0] ZM_1 = 2'd1;
    localparam logic [1:0] ZM_2 = 2'd2;

    localparam logic [PAT_W-1:0] PAT_0 = 2'd0;
    localparam logic [PAT_W-1:0] PAT_1 = 2'd1;
    localparam logic [PAT_W-1:0] PAT_2 = 2'd2;

    // bit window of the three words around the current bit
    typedef struct packed {
        logic cur;
        logic prev_lo;
        logic prev_mid;
        logic prev_hi;
        logic old_lo;
        logic old_mid;
        logic old_hi;
    } win_t;

    // control from the sequencer to the word shift registers
    typedef struct packed {
        logic load;
        logic rotate;
        logic first;
        logic last;
        logic commit;
        logic keep;
        logic join_grp;
        logic clear;
    } shift_ctl_t;

    typedef struct packed {
        logic [CELL_Z_W-1:0]    z;
        logic [CELL_WIRE_W-1:0] wire_no;
    } cell_t;

    typedef struct packed {
        logic pend_valid;
        logic out_free;
    } out_stat_t;

    // offset into the previous word
    function automatic off_t pat_prev_off(input logic [1:0] zm, input logic [PAT_W-1:0] p);
        off_t r;
        r = OFF_ZERO;
        unique case ({zm, p})
            {ZM_0, PAT_0}: r = OFF_ZERO;
            {ZM_0, PAT_1}: r = OFF_ZERO;
            {ZM_0, PAT_2}: r = OFF_PLUS;
            {ZM_1, PAT_0}: r = OFF_ZERO;
            {ZM_1, PAT_1}: r = OFF_ZERO;
            {ZM_1, PAT_2}: r = OFF_PLUS;
            {ZM_2, PAT_0}: r = OFF_ZERO;
            {ZM_2, PAT_1}: r = OFF_MINUS;
            {ZM_2, PAT_2}: r = OFF_MINUS;
            default:       r = OFF_ZERO;
        endcase
        return r;
    endfunction

    // offset into the word before the previous one
    function automatic off_t pat_old_off(input logic [1:0] zm, input logic [PAT_W-1:0] p);
        off_t r;
        r = OFF_ZERO;
        unique case ({zm, p})
            {ZM_0, PAT_0}: r = OFF_ZERO;
            {ZM_0, PAT_1}: r = OFF_PLUS;
            {ZM_0, PAT_2}: r = OFF_PLUS;
            {ZM_1, PAT_0}: r = OFF_ZERO;
            {ZM_1, PAT_1}: r = OFF_MINUS;
            {ZM_1, PAT_2}: r = OFF_ZERO;
            {ZM_2, PAT_0}: r = OFF_ZERO;
            {ZM_2, PAT_1}: r = OFF_MINUS;
            {ZM_2, PAT_2}: r = OFF_ZERO;
            default:       r = OFF_ZERO;
        endcase
        return r;
    endfunction

    // pad at bit b - off out of a three-bit window
    function automatic logic sel_bit(input logic lo, input logic mid, input logic hi,
                                     input off_t off);
        logic r;
        r = 1'b0;
        unique case (off)
            OFF_PLUS:  r = lo;
            OFF_ZERO:  r = mid;
            OFF_MINUS: r = hi;
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

    // 8-bit value mod 3: base-4 digits each weigh 1 mod 3
    function automatic logic [1:0] mod3_8(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[3:2]) + 3'(s[1:0]);
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// ===== hw/rtl/pwcf_in_if.sv =====
interface pwcf_in_if
    import pwcf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PAD_WORD_W-1:0] pad_word;
    logic [INDEX_W-1:0]    word_index;
    logic                  end_of_event;

    modport source (output valid, pad_word, word_index, end_of_event, input ready);
    modport sink   (input valid, pad_word, word_index, end_of_event, output ready);
endinterface

// ===== hw/rtl/pwcf_out_if.sv =====
interface pwcf_out_if
    import pwcf_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CELL_Z_W-1:0]    cell_z;
    logic [CELL_WIRE_W-1:0] cell_wire;
    logic                   last_cell;

    modport source (output valid, cell_z, cell_wire, last_cell, input ready);
    modport sink   (input valid, cell_z, cell_wire, last_cell, output ready);
endinterface

// ===== hw/rtl/pwcf_word_shift.sv =====
module pwcf_word_shift
    import pwcf_pkg::*;
#(
    parameter int PADS_PER_WORD = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PAD_WORD_W-1:0] pad_word,
    input  shift_ctl_t            ctl,
    output win_t                  win
);

    localparam int P = PADS_PER_WORD;

    logic [P-1:0] cur_reg, cur_next;
    logic [P-1:0] prev_reg, prev_next;
    logic [P-1:0] old_reg, old_next;
    logic [PAD_WORD_W+P-1:0] ext;

    assign ext = {{P{1'b0}}, pad_word};

    // rotating right by one per bit, the words are back in place after P steps
    always_comb
    begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        old_next  = old_reg;
        if (ctl.load)
        begin
            cur_next = ext[P-1:0];
        end
        else if (ctl.rotate)
        begin
            cur_next  = {cur_reg[0], cur_reg[P-1:1]};
            prev_next = {prev_reg[0], prev_reg[P-1:1]};
            old_next  = {old_reg[0], old_reg[P-1:1]};
        end
        else if (ctl.commit)
        begin
            if (ctl.clear)
            begin
                prev_next = '0;
                old_next  = '0;
            end
            else if (ctl.keep)
            begin
                old_next  = ctl.join_grp ? prev_reg : '0;
                prev_next = cur_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            prev_reg <= '0;
            old_reg  <= '0;
        end
        else
        begin
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
            old_reg  <= old_next;
        end
    end

    // neighbors off the word edge read as empty
    always_comb
    begin
        win.cur      = cur_reg[0];
        win.prev_mid = prev_reg[0];
        win.old_mid  = old_reg[0];
        win.prev_lo  = ctl.first ? 1'b0 : prev_reg[P-1];
        win.old_lo   = ctl.first ? 1'b0 : old_reg[P-1];
        win.prev_hi  = ctl.last ? 1'b0 : prev_reg[1];
        win.old_hi   = ctl.last ? 1'b0 : old_reg[1];
    end

endmodule

// ===== hw/rtl/pwcf_cell_out.sv =====
module pwcf_cell_out
    import pwcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_t             hit,
    input  logic              new_cell,
    input  logic              flush,
    output out_stat_t         stat,
    pwcf_out_if.source        cells
);

    logic  pend_valid_reg, pend_valid_next;
    cell_t pend_reg, pend_next;
    logic  out_valid_reg, out_valid_next;
    cell_t out_reg, out_next;
    logic  out_last_reg, out_last_next;
    logic  out_free;

    assign out_free = !out_valid_reg || cells.ready;

    // one cell held back so the final one of an item can be marked
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && cells.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (new_cell)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = hit;
        end
        else if (flush && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign cells.valid     = out_valid_reg;
    assign cells.cell_z    = out_reg.z;
    assign cells.cell_wire = out_reg.wire_no;
    assign cells.last_cell = out_last_reg;

endmodule

// ===== hw/rtl/pad_word_cell_finder.sv =====
// Pad word cell finder. Fired-pad words of one event come in on the words
// channel in word order; words at consecutive indices whose pads touch (same
// pad or a neighbor) form a group, and from the third word of a group on every
// fired pad is tested against three pad patterns in the two earlier words, the
// pattern set picked by cell z mod 3. Each match gives one cell item (z, wire)
// on the cells channel, lowest pad first and patterns in order, with last_cell
// set on the final cell of a word; a word gives at most 60 cells and further
// matches are dropped. A zero word or one with an index at or
// beyond WORDS_PER_EVENT gives nothing and leaves the group alone; end_of_event
// clears the group after its word. The three words sit in rotating shift
// registers and are scanned one pad per cycle; a pad is held while it has
// further matches found on it or while the cells side holds off the output.
// A word is taken only between scans; one finished cell waits in the pending
// register while the next is found.
module pad_word_cell_finder
    import pwcf_pkg::*;
#(
    parameter int WORDS_PER_EVENT = 108,
    parameter int PADS_PER_WORD   = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    pwcf_in_if.sink    words,
    pwcf_out_if.source cells
);

    localparam int P     = PADS_PER_WORD;
    localparam int BIT_W = $clog2(P);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(P - 1);
    localparam logic [8:0] WPE = 9'(WORDS_PER_EVENT);
    localparam logic [CELL_WIRE_W-1:0] BASE0 = CELL_WIRE_W'(((P - 1) * 3) % 64);
    localparam logic [CELL_WIRE_W-1:0] WIRE_STEP = CELL_WIRE_W'(3);
    localparam logic [5:0] CELL_CAP = 6'(MAX_ITEM_CELLS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg, state_next;

    // group state
    logic [INDEX_W-1:0] prev_index_reg, prev_index_next;
    logic [1:0]         group_len_reg, group_len_next;

    // per item
    logic [INDEX_W-1:0]     idx_reg, idx_next;
    logic                   eoe_reg, eoe_next;
    logic [CELL_Z_W-1:0]    z_reg, z_next;
    logic [1:0]             zm_reg, zm_next;
    logic                   idx_ok_reg, idx_ok_next;
    logic                   emit_en_reg, emit_en_next;
    logic                   try_join_reg, try_join_next;

    // scan
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [CELL_WIRE_W-1:0] base_reg, base_next;
    logic [NUM_PAT-1:0]     done_reg, done_next;
    logic                   nz_reg, nz_next;
    logic                   ov_reg, ov_next;
    // cells found so far for this item
    logic [5:0]             cnt_reg, cnt_next;

    logic [7:0]         z_full;
    logic               idx_ok, consec;
    win_t               win;
    shift_ctl_t         ctl;
    out_stat_t          ostat;
    logic [NUM_PAT-1:0] match, rem, rem_after, pick_vec;
    logic [PAT_W-1:0]   pick;
    logic               can_emit, emit, advance, finish, flush;
    off_t               d0, d1;
    logic signed [2:0]  dsum;
    cell_t              hit;

    assign words.ready = (state_reg == ST_IDLE);

    // z of the incoming word and its group relation
    assign z_full = 8'(WPE - 9'd1 - 9'(words.word_index));
    assign idx_ok = 9'(words.word_index) < WPE;
    assign consec = 8'(words.word_index) == 8'(prev_index_reg) + 8'd1;

    // pattern matches at the current pad
    always_comb
    begin
        for (int p = 0; p < NUM_PAT; p++)
        begin
            match[p] = emit_en_reg && win.cur
                && sel_bit(win.prev_lo, win.prev_mid, win.prev_hi,
                           pat_prev_off(zm_reg, PAT_W'(p)))
                && sel_bit(win.old_lo, win.old_mid, win.old_hi,
                           pat_old_off(zm_reg, PAT_W'(p)));
        end
    end

    // once the cap is reached the rest of the scan gives nothing
    assign rem = (state_reg == ST_SCAN && cnt_reg != CELL_CAP) ? (match & ~done_reg) : '0;

    // lowest pattern still open at this pad
    always_comb
    begin
        pick     = PAT_0;
        pick_vec = '0;
        if (rem[0])
        begin
            pick     = PAT_0;
            pick_vec = 3'b001;
        end
        else if (rem[1])
        begin
            pick     = PAT_1;
            pick_vec = 3'b010;
        end
        else if (rem[2])
        begin
            pick     = PAT_2;
            pick_vec = 3'b100;
        end
    end

    assign rem_after = rem & ~pick_vec;
    assign can_emit  = !ostat.pend_valid || ostat.out_free;
    assign emit      = (rem != '0) && can_emit;
    assign advance   = (state_reg == ST_SCAN)
                       && ((rem == '0) || (emit && rem_after == '0));
    assign finish    = (state_reg == ST_FLUSH) && can_emit;
    assign flush     = finish && ostat.pend_valid;

    assign d0   = pat_prev_off(zm_reg, pick);
    assign d1   = pat_old_off(zm_reg, pick);
    assign dsum = 3'(d0) + 3'(d1);

    assign hit.z       = z_reg;
    assign hit.wire_no = base_reg + {{(CELL_WIRE_W-3){dsum[2]}}, dsum};

    always_comb
    begin
        ctl.load     = words.valid && words.ready;
        ctl.rotate   = advance;
        ctl.first    = (bit_reg == '0);
        ctl.last     = (bit_reg == LAST_BIT);
        ctl.commit   = finish;
        ctl.keep     = idx_ok_reg && nz_reg;
        ctl.join_grp = try_join_reg && ov_reg;
        ctl.clear    = eoe_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        prev_index_next = prev_index_reg;
        group_len_next  = group_len_reg;
        idx_next        = idx_reg;
        eoe_next        = eoe_reg;
        z_next          = z_reg;
        zm_next         = zm_reg;
        idx_ok_next     = idx_ok_reg;
        emit_en_next    = emit_en_reg;
        try_join_next   = try_join_reg;
        bit_next        = bit_reg;
        base_next       = base_reg;
        done_next       = done_reg;
        nz_next         = nz_reg;
        ov_next         = ov_reg;
        cnt_next        = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (words.valid)
                begin
                    idx_next      = words.word_index;
                    eoe_next      = words.end_of_event;
                    z_next        = z_full[CELL_Z_W-1:0];
                    zm_next       = mod3_8(z_full);
                    idx_ok_next   = idx_ok;
                    try_join_next = idx_ok && (group_len_reg != 2'd0) && consec;
                    emit_en_next  = idx_ok && (group_len_reg >= 2'd2) && consec;
                    bit_next      = '0;
                    base_next     = BASE0;
                    done_next     = '0;
                    nz_next       = 1'b0;
                    ov_next       = 1'b0;
                    cnt_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (emit)
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
                if (emit && rem_after != '0)
                begin
                    done_next = done_reg | pick_vec;
                end
                if (advance)
                begin
                    done_next = '0;
                    bit_next  = bit_reg + BIT_W'(1);
                    base_next = base_reg - WIRE_STEP;
                    nz_next   = nz_reg | win.cur;
                    ov_next   = ov_reg | (win.cur
                                & (win.prev_lo | win.prev_mid | win.prev_hi));
                    if (bit_reg == LAST_BIT)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (finish)
                begin
                    if (idx_ok_reg && nz_reg)
                    begin
                        prev_index_next = idx_reg;
                        if (try_join_reg && ov_reg)
                        begin
                            if (group_len_reg != 2'd3)
                            begin
                                group_len_next = group_len_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            group_len_next = 2'd1;
                        end
                    end
                    if (eoe_reg)
                    begin
                        prev_index_next = '0;
                        group_len_next  = 2'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_index_reg <= '0;
            group_len_reg  <= 2'd0;
            idx_ok_reg     <= 1'b0;
            emit_en_reg    <= 1'b0;
            try_join_reg   <= 1'b0;
            eoe_reg        <= 1'b0;
            bit_reg        <= '0;
            done_reg       <= '0;
            nz_reg         <= 1'b0;
            ov_reg         <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_index_reg <= prev_index_next;
            group_len_reg  <= group_len_next;
            idx_ok_reg     <= idx_ok_next;
            emit_en_reg    <= emit_en_next;
            try_join_reg   <= try_join_next;
            eoe_reg        <= eoe_next;
            bit_reg        <= bit_next;
            done_reg       <= done_next;
            nz_reg         <= nz_next;
            ov_reg         <= ov_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        z_reg    <= z_next;
        zm_reg   <= zm_next;
        base_reg <= base_next;
    end

    pwcf_word_shift #(
        .PADS_PER_WORD (PADS_PER_WORD)
    ) u_word_shift (
        .clk      (clk),
        .rst_n    (rst_n),
        .pad_word (words.pad_word),
        .ctl      (ctl),
        .win      (win)
    );

    pwcf_cell_out u_cell_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .hit      (hit),
        .new_cell (emit),
        .flush    (flush),
        .stat     (ostat),
        .cells    (cells)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    import pwcf_pkg::*;

    // block configuration, left at the defaults of the top level
    localparam int WORDS_PER_EVENT = 108;
    localparam int PADS_PER_WORD   = 20;

    localparam int HALF_PERIOD  = 6;
    localparam int IDLE_PCT     = 36;
    localparam int RANDOM_ITEMS = 56;
    localparam int QUIET_ITEMS  = 30;
    localparam int MAX_CELLS    = 60;
    // time after the last cell to watch for stray cells
    localparam int DRAIN_CYCLES = 4 * (PADS_PER_WORD + 2);
    // worst case is about 150 words, each 60 cells under long stalls; several times over
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [PAD_WORD_W-1:0] ALL_PADS = {PADS_PER_WORD{1'b1}};

    typedef struct packed {
        logic [CELL_Z_W-1:0]    z;
        logic [CELL_WIRE_W-1:0] wire_no;
        logic                   last_cell;
    } cell_exp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet;
    int   err_count = 0;
    int   items_sent = 0;
    int   cycle_count = 0;

    // cells the block still owes, oldest first
    cell_exp_t expected_cells[$];
    cell_exp_t oldest_cell;

    // group state of the predictor
    logic [PAD_WORD_W-1:0] last_word;
    logic [PAD_WORD_W-1:0] older_word;
    int                    last_index;
    int                    group_len;

    pwcf_in_if  words();
    pwcf_out_if cells();

    pad_word_cell_finder u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .words (words),
        .cells (cells)
    );

    always #HALF_PERIOD clk = ~clk;

    // hard stop if the block hangs or drops a cell
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // cells side: stalls at random unless in a quiet stretch
    always @(posedge clk)
    begin
        cells.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // every accepted cell is matched against the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && cells.valid && cells.ready)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("unexpected cell z %0d wire %0d", cells.cell_z, cells.cell_wire);
                err_count++;
            end
            else
            begin
                oldest_cell = expected_cells.pop_front();
                if (cells.cell_z !== oldest_cell.z)
                begin
                    $error("cell_z expected %0d got %0d", oldest_cell.z, cells.cell_z);
                    err_count++;
                end
                if (cells.cell_wire !== oldest_cell.wire_no)
                begin
                    $error("cell_wire expected %0d got %0d", oldest_cell.wire_no,
                           cells.cell_wire);
                    err_count++;
                end
                if (cells.last_cell !== oldest_cell.last_cell)
                begin
                    $error("last_cell expected %0d got %0d", oldest_cell.last_cell,
                           cells.last_cell);
                    err_count++;
                end
            end
        end
    end

    function automatic void clear_group();
        last_word  = '0;
        older_word = '0;
        last_index = 0;
        group_len  = 0;
    endfunction

    // pad of a word at bit b; pads off either edge never fire
    function automatic logic pad_fired(input logic [PAD_WORD_W-1:0] w, input int b);
        if (b < 0 || b >= PADS_PER_WORD)
        begin
            return 1'b0;
        end
        return w[b];
    endfunction

    // where each pattern looks in the previous word and the one before it
    function automatic void pattern_offsets(input logic [1:0] zm, input logic [PAT_W-1:0] p,
                                            output int d_prev, output int d_old);
        d_prev = 0;
        d_old  = 0;
        case ({zm, p})
            {ZM_0, PAT_1}: d_old = 1;
            {ZM_0, PAT_2}: begin d_prev = 1; d_old = 1; end
            {ZM_1, PAT_1}: d_old = -1;
            {ZM_1, PAT_2}: d_prev = 1;
            {ZM_2, PAT_1}: begin d_prev = -1; d_old = -1; end
            {ZM_2, PAT_2}: d_prev = -1;
            default:       ;
        endcase
    endfunction

    // group tracking and pattern search for one accepted word
    function automatic void predict_cells(input logic [PAD_WORD_W-1:0] pad,
                                          input logic [INDEX_W-1:0] idx, input logic eoe);
        logic [PAD_WORD_W-1:0] data;
        cell_exp_t             word_cells[$];
        cell_exp_t             c;
        int                    z;
        int                    d_prev;
        int                    d_old;
        bit                    joins;
        data  = pad & ALL_PADS;
        joins = 1'b0;
        // zero words and words past the event end leave the group alone
        if (data != '0 && int'(idx) < WORDS_PER_EVENT)
        begin
            if (group_len != 0 && int'(idx) == last_index + 1)
            begin
                joins = (last_word & (data | (data << 1) | (data >> 1))) != '0;
            end
            if (joins)
            begin
                if (group_len >= 2)
                begin
                    z = WORDS_PER_EVENT - 1 - int'(idx);
                    for (int b = 0; b < PADS_PER_WORD; b++)
                    begin
                        if (data[b])
                        begin
                            for (int p = 0; p < NUM_PAT; p++)
                            begin
                                pattern_offsets(2'(z % 3), PAT_W'(p), d_prev, d_old);
                                if (pad_fired(last_word, b - d_prev) &&
                                    pad_fired(older_word, b - d_old) &&
                                    word_cells.size() < MAX_CELLS)
                                begin
                                    c.z         = CELL_Z_W'(z);
                                    c.wire_no   = CELL_WIRE_W'((PADS_PER_WORD - 1 - b) * 3
                                                               + d_prev + d_old);
                                    c.last_cell = 1'b0;
                                    word_cells = {word_cells, c};
                                end
                            end
                        end
                    end
                end
                older_word = last_word;
                if (group_len < 3)
                begin
                    group_len++;
                end
            end
            else
            begin
                older_word = '0;
                group_len  = 1;
            end
            last_word  = data;
            last_index = int'(idx);
        end
        foreach (word_cells[i])
        begin
            c              = word_cells[i];
            c.last_cell    = (i == word_cells.size() - 1);
            expected_cells = {expected_cells, c};
        end
        if (eoe)
        begin
            clear_group();
        end
    endfunction

    // offer one item, wait for the handshake, then maybe idle for a while
    task automatic send_word(input logic [PAD_WORD_W-1:0] pad, input int idx, input bit eoe);
        words.valid        <= 1'b1;
        words.pad_word     <= pad;
        words.word_index   <= INDEX_W'(idx);
        words.end_of_event <= eoe;
        @(posedge clk);
        while (!words.ready)
        begin
            @(posedge clk);
        end
        predict_cells(pad, INDEX_W'(idx), eoe);
        items_sent++;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            // idle payload is junk on purpose
            words.valid        <= 1'b0;
            words.pad_word     <= PAD_WORD_W'($urandom);
            words.word_index   <= INDEX_W'($urandom);
            words.end_of_event <= 1'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // non-zero word of random density
    function automatic logic [PAD_WORD_W-1:0] random_pads();
        logic [PAD_WORD_W-1:0] w;
        case ($urandom_range(0, 3))
            0:       w = PAD_WORD_W'($urandom);
            1:       w = PAD_WORD_W'($urandom & $urandom);
            2:       w = PAD_WORD_W'($urandom & $urandom & $urandom);
            default: w = '0;
        endcase
        if (w == '0)
        begin
            w[$urandom_range(0, PADS_PER_WORD - 1)] = 1'b1;
        end
        return w & ALL_PADS;
    endfunction

    // next word of a track: a shifted, lightly edited copy that surely touches prev
    function automatic logic [PAD_WORD_W-1:0] neighbor_pads(input logic [PAD_WORD_W-1:0] prev);
        logic [PAD_WORD_W-1:0] w;
        int                    b;
        do
        begin
            b = $urandom_range(0, PADS_PER_WORD - 1);
        end
        while (!prev[b]);
        case ($urandom_range(0, 2))
            0:       w = prev;
            1:       w = prev << 1;
            default: w = prev >> 1;
        endcase
        w    = (w & ~PAD_WORD_W'($urandom & $urandom & $urandom))
             | PAD_WORD_W'($urandom & $urandom & $urandom);
        w[b] = 1'b1;
        return w & ALL_PADS;
    endfunction

    // one event as a run of consecutive words, now and then broken up by noise
    task automatic run_event(input int n_words);
        logic [PAD_WORD_W-1:0] w;
        logic [PAD_WORD_W-1:0] touch;
        int                    idx;
        idx = $urandom_range(0, WORDS_PER_EVENT - n_words);
        w   = random_pads();
        for (int k = 0; k < n_words; k++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                case ($urandom_range(0, 3))
                    // zero word inside the run, ignored
                    0: send_word('0, idx, 1'b0);
                    // index past the event end, ignored
                    1: send_word(random_pads(), $urandom_range(WORDS_PER_EVENT, 127), 1'b0);
                    // index gap breaks the group
                    2: idx++;
                    // word with no pad next to the word it replaces, which may break the group
                    default:
                    begin
                        touch = w | (w << 1) | (w >> 1);
                        w     = random_pads() & ~touch;
                    end
                endcase
            end
            send_word(w, idx, k == n_words - 1);
            w = neighbor_pads(w == '0 ? random_pads() : w);
            idx++;
        end
    endtask

    // extremes of every field and each special case
    task automatic test_directed_cases();
        // zero word and indices past the event end give nothing
        send_word('0, 3, 1'b0);
        send_word(ALL_PADS, WORDS_PER_EVENT, 1'b0);
        send_word(ALL_PADS, 127, 1'b0);
        // full words from index 0: every pad fires, all three z mod 3 sets used
        send_word(ALL_PADS, 0, 1'b0);
        send_word(ALL_PADS, 1, 1'b0);
        send_word(ALL_PADS, 2, 1'b0);
        send_word(ALL_PADS, 3, 1'b0);
        send_word(ALL_PADS, 4, 1'b1);
        // zero and out-of-range words inside a group do not break it
        send_word(20'h00001, 10, 1'b0);
        send_word(20'h00002, 11, 1'b0);
        send_word('0, 12, 1'b0);
        send_word(20'h00003, 120, 1'b0);
        send_word(20'h00003, 12, 1'b0);
        send_word(20'h00004, 13, 1'b0);
        // index gap, then a word with no neighbor in the previous one
        send_word(20'h00004, 15, 1'b0);
        send_word(20'h80000, 16, 1'b0);
        // top pad edge
        send_word(20'h80000, 17, 1'b0);
        send_word(20'hC0000, 18, 1'b0);
        send_word(20'hC0000, 19, 1'b1);
        // group is gone after end of event
        send_word(20'hC0000, 20, 1'b0);
        // end of event on an ignored word still clears
        send_word('0, 50, 1'b1);
        // bottom pad edge at the last index, z of zero
        send_word(20'h00001, 105, 1'b0);
        send_word(20'h00003, 106, 1'b0);
        send_word(20'h00001, 107, 1'b1);
    endtask

    // mostly well-formed events, the rest stray words
    task automatic test_random_traffic(input int target);
        int n;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                : $urandom_range(1, 6);
                run_event(n);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                send_word('0, $urandom_range(0, 127), $urandom_range(0, 4) == 0);
            end
            else
            begin
                send_word(random_pads(), $urandom_range(0, 127), $urandom_range(0, 4) == 0);
            end
        end
    endtask

    // both sides at full rate
    task automatic test_back_to_back();
        quiet = 1'b1;
        test_random_traffic(items_sent + QUIET_ITEMS);
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        quiet              = 1'b0;
        words.valid        = 1'b0;
        words.pad_word     = '0;
        words.word_index   = '0;
        words.end_of_event = 1'b0;
        cells.ready        = 1'b0;
        clear_group();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(items_sent + RANDOM_ITEMS);
        test_back_to_back();
        words.valid <= 1'b0;

        // let the last cells out, then watch for strays
        while (expected_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
